>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the chord edge detector.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define BCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be true outside reset
`define BCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BCD_ASSERT(lbl, prop, msg)
`define BCD_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/bcd_pkg.sv
// Package of the button chord edge detector: sizes, slot and queue types.
// Used by every module under rtl/core; depends on nothing.
package bcd_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int BUTTON_BITS = 16;
  localparam int PLAYER_BITS = 6;
  localparam int SLOT_BITS   = 3;
  localparam int REG_BITS    = BUTTON_BITS + 1;
  localparam int ADDR_BITS   = SLOT_BITS + 2;
  localparam int APB_BITS    = 32;
  // queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // packed stream widths
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 16;

  typedef struct packed {
    logic                   en;
    logic [BUTTON_BITS-1:0] mask;
  } slot_cfg_t;

  // one classified sample waiting for the event sequencer
  typedef struct packed {
    logic [PLAYER_BITS-1:0] player;
    logic [SLOT_COUNT-1:0]  fire;
    logic [SLOT_COUNT-1:0]  press;
  } sample_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

>>> rtl/core/button_chord_edge_detector_unit.sv
// Button chord edge detector, top level.
// Input stream (s_axis): one button sample per transaction, holding the
// player index, the current and the previous button words. Eight chord
// slots, each a 16-bit mask plus an enable, are set over the APB port.
// Output stream (m_axis): one transaction per chord event, lowest slot
// first; tuser is 1 for a press and 0 for a release, tlast marks the
// final event of a sample. A sample with no event produces nothing.
// Throughput: one event per cycle while the receiver is ready. A sample
// with no event is dropped in its input cycle; one with events holds the
// sequencer, and the two-entry sample queue lets the input keep moving
// while its events drain. A stalled receiver holds the output register;
// the queue then fills and s_axis_tready drops. Reset clears all chord
// slots, the queue and the output register. Slots must be written only
// while no sample is in flight; the block does not enforce this.
// Depends on bcd_pkg, bcd_cfg, bcd_front, bcd_queue, bcd_back.
`include "assert_macros.svh"

module button_chord_edge_detector_unit
  import bcd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [APB_BITS-1:0]      pwdata,
  output logic [APB_BITS-1:0]      prdata,
  output logic                     pready,
  // sample stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [5:0] player_index, [21:6] current_buttons, [37:22] previous_buttons
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // event stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [5:0] event_player, [8:6] event_slot
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // [0] event_pressed
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast
);

  slot_cfg_t              slot_cfg [SLOT_COUNT];
  queue_stat_t            q_stat;
  sample_t                push_data, pop_data;
  logic                   push, pop;
  logic [PLAYER_BITS-1:0] ev_player;
  logic [SLOT_BITS-1:0]   ev_slot;

  bcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slot_cfg_o (slot_cfg)
  );

  bcd_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .player_i   (s_axis_tdata[PLAYER_BITS-1:0]),
    .now_i      (s_axis_tdata[PLAYER_BITS+BUTTON_BITS-1:PLAYER_BITS]),
    .before_i   (s_axis_tdata[PLAYER_BITS+2*BUTTON_BITS-1:PLAYER_BITS+BUTTON_BITS]),
    .slot_cfg_i (slot_cfg),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .sample_o   (push_data)
  );

  bcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (q_stat)
  );

  bcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (pop_data),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_player_o  (ev_player),
    .out_slot_o    (ev_slot),
    .out_pressed_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_BITS-PLAYER_BITS-SLOT_BITS){1'b0}}, ev_slot, ev_player};

  // an event only ever comes from an enabled slot
  `BCD_ASSERT(a_event_slot_enabled, m_axis_tvalid |-> slot_cfg[ev_slot].en, "event from disabled slot")
  // the queue is never written while full
  `BCD_NEVER(a_queue_overflow, push && q_stat.full, "sample queue overflow")
  // events of one sample come out in ascending slot order
  `BCD_ASSERT(a_slot_order, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid || (ev_slot > $past(ev_slot))), "slot order broken")

endmodule

>>> rtl/core/bcd_cfg.sv
// APB register file holding the chord slot masks and enables.
// Depends on bcd_pkg.
module bcd_cfg
  import bcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [APB_BITS-1:0]   pwdata,
  output logic [APB_BITS-1:0]   prdata,
  output logic                  pready,
  output slot_cfg_t             slot_cfg_o [SLOT_COUNT]
);

  logic [REG_BITS-1:0]  slot_q [SLOT_COUNT];
  logic [SLOT_BITS-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;

  // register writes, bits above the enable dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= '0;
      end
    end else if (wr_en) begin
      slot_q[idx] <= pwdata[REG_BITS-1:0];
    end
  end

  // read back
  assign prdata = {{(APB_BITS-REG_BITS){1'b0}}, slot_q[idx]};

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_cfg_o[i].en   = slot_q[i][BUTTON_BITS];
      slot_cfg_o[i].mask = slot_q[i][BUTTON_BITS-1:0];
    end
  end

endmodule

>>> rtl/core/bcd_front.sv
// Front end: takes a button sample and classifies every slot at once.
// Depends on bcd_pkg; feeds the sample queue.
module bcd_front
  import bcd_pkg::*;
(
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PLAYER_BITS-1:0] player_i,
  input  logic [BUTTON_BITS-1:0] now_i,
  input  logic [BUTTON_BITS-1:0] before_i,
  input  slot_cfg_t              slot_cfg_i [SLOT_COUNT],
  input  queue_stat_t            q_stat_i,
  output logic                   push_o,
  output sample_t                sample_o
);

  logic [SLOT_COUNT-1:0] held_now;
  logic [SLOT_COUNT-1:0] held_before;

  // per-slot chord state now and before
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      held_now[i]    = (now_i & slot_cfg_i[i].mask) == slot_cfg_i[i].mask;
      held_before[i] = (before_i & slot_cfg_i[i].mask) == slot_cfg_i[i].mask;
      sample_o.fire[i] = slot_cfg_i[i].en && (held_now[i] != held_before[i]);
    end
    sample_o.press  = held_now;
    sample_o.player = player_i;
  end

  assign in_ready_o = !q_stat_i.full;
  // samples with no event are dropped here
  assign push_o = in_valid_i && in_ready_o && (|sample_o.fire);

endmodule

>>> rtl/core/bcd_queue.sv
// Short queue of classified samples between front end and sequencer.
// Depends on bcd_pkg.
module bcd_queue
  import bcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sample_t     data_i,
  input  logic        pop_i,
  output sample_t     data_o,
  output queue_stat_t stat_o
);

  sample_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign stat_o.valid = cnt_q != '0;
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bcd_back.sv
// Event sequencer: walks the fired slots of one sample, lowest first,
// one event per cycle into the free output register. Depends on bcd_pkg.
module bcd_back
  import bcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sample_t                sample_i,
  input  queue_stat_t            q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PLAYER_BITS-1:0] out_player_o,
  output logic [SLOT_BITS-1:0]   out_slot_o,
  output logic                   out_pressed_o,
  output logic                   out_last_o
);

  logic                   cur_valid_q, cur_valid_d;
  logic [PLAYER_BITS-1:0] cur_player_q, cur_player_d;
  logic [SLOT_COUNT-1:0]  cur_fire_q, cur_fire_d;
  logic [SLOT_COUNT-1:0]  cur_press_q, cur_press_d;

  logic                   out_valid_q, out_valid_d;
  logic [PLAYER_BITS-1:0] out_player_q, out_player_d;
  logic [SLOT_BITS-1:0]   out_slot_q, out_slot_d;
  logic                   out_pressed_q, out_pressed_d;
  logic                   out_last_q, out_last_d;

  logic [SLOT_BITS-1:0]   low_idx;
  logic [SLOT_COUNT-1:0]  rest;
  logic                   is_last, out_free, emit;

  // lowest fired slot of the current sample
  always_comb begin
    low_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cur_fire_q[i]) low_idx = SLOT_BITS'(i);
    end
  end

  assign rest     = cur_fire_q & (cur_fire_q - 1'b1);
  assign is_last  = rest == '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign pop_o    = q_stat_i.valid && (!cur_valid_q || (emit && is_last));

  // current sample and output register next state
  always_comb begin
    cur_valid_d   = cur_valid_q;
    cur_player_d  = cur_player_q;
    cur_fire_d    = cur_fire_q;
    cur_press_d   = cur_press_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_player_d  = out_player_q;
    out_slot_d    = out_slot_q;
    out_pressed_d = out_pressed_q;
    out_last_d    = out_last_q;
    if (emit) begin
      out_valid_d   = 1'b1;
      out_player_d  = cur_player_q;
      out_slot_d    = low_idx;
      out_pressed_d = cur_press_q[low_idx];
      out_last_d    = is_last;
      cur_fire_d    = rest;
      cur_valid_d   = !is_last;
    end
    if (pop_o) begin
      cur_valid_d  = 1'b1;
      cur_player_d = sample_i.player;
      cur_fire_d   = sample_i.fire;
      cur_press_d  = sample_i.press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_player_q  <= cur_player_d;
    cur_fire_q    <= cur_fire_d;
    cur_press_q   <= cur_press_d;
    out_player_q  <= out_player_d;
    out_slot_q    <= out_slot_d;
    out_pressed_q <= out_pressed_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_player_o  = out_player_q;
  assign out_slot_o    = out_slot_q;
  assign out_pressed_o = out_pressed_q;
  assign out_last_o    = out_last_q;

endmodule
